FILE: rtl/fps_pkg.sv
// Shared widths, opcodes and controller/datapath interface types for the prefix-sum table.
package fps_pkg;

  localparam int DATA_W  = 32;
  localparam int POS_W   = 10;
  localparam int CNT_W   = 11;
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Commands issued by the controller to the datapath.
  typedef struct packed {
    logic start;     // latch a new item and load the first node
    logic clr_step;  // write zero at the clear address and advance it
    logic add_rd;    // read the current node for an add
    logic add_wr;    // write node plus delta and move to the parent
    logic q_step;    // read the current node for a query and move down
    logic q_neg;     // reads issued now are subtracted
    logic load_lo;   // start the lower prefix walk
    logic out_load;  // capture the finished total
  } cmd_t;

  // Status returned by the datapath.
  typedef struct packed {
    logic add_skip;     // add position lies at or past the used count
    logic node_zero;    // downward walk has finished
    logic up_in_range;  // next node of an upward walk is still in use
    logic clr_last;     // clear pass is at its last entry
  } sts_t;

endpackage

FILE: rtl/fps_controller.sv
// Sequencing state machine for the clear pass, add walks and range-sum walks.
module fps_controller import fps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic operation_i,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o,
  output logic out_valid_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_ADD_RD = 3'd2;
  localparam logic [2:0] ST_ADD_WR = 3'd3;
  localparam logic [2:0] ST_Q_HI   = 3'd4;
  localparam logic [2:0] ST_Q_LO   = 3'd5;
  localparam logic [2:0] ST_Q_DONE = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          if (operation_i == OP_QUERY) begin
            state_d = ST_Q_HI;
          end else if (!sts_i.add_skip) begin
            state_d = ST_ADD_RD;
          end
        end
      end
      ST_ADD_RD: begin
        cmd_o.add_rd = 1'b1;
        state_d      = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = sts_i.up_in_range ? ST_ADD_RD : ST_IDLE;
      end
      ST_Q_HI: begin
        if (sts_i.node_zero) begin
          cmd_o.load_lo = 1'b1;
          state_d       = ST_Q_LO;
        end else begin
          cmd_o.q_step = 1'b1;
        end
      end
      ST_Q_LO: begin
        cmd_o.q_neg = 1'b1;
        if (sts_i.node_zero) begin
          state_d = ST_Q_DONE;
        end else begin
          cmd_o.q_step = 1'b1;
        end
      end
      ST_Q_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/fps_datapath.sv
// Tree memory, node walker, accumulator and result register of the prefix-sum table.
module fps_datapath import fps_pkg::*; #(
  parameter int MAX_ELEMS = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic [CNT_W-1:0]         elem_count_i,
  input  logic                     operation_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] delta_i,
  input  logic [POS_W-1:0]         range_low_i,
  input  logic [POS_W-1:0]         range_high_i,
  output logic signed [DATA_W-1:0] range_total_o
);

  localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int CW = $clog2(MAX_ELEMS) + 2;
  localparam int NW = (CW > CNT_W + 1) ? CW : CNT_W + 1;
  localparam logic [NW-1:0] MAX_NODE = NW'(MAX_ELEMS);

  logic [DATA_W-1:0] mem [MAX_ELEMS];

  logic [NW-1:0]     node_q, node_d;
  logic [NW-1:0]     used_cnt, count_ext, low_bit, node_up, node_dn, pos_ext;
  logic [AW-1:0]     node_addr, wr_addr;
  logic              in_range, rd_en, wr_en;
  logic [DATA_W-1:0] rd_data_q, wr_data;
  logic [DATA_W-1:0] delta_q, acc_q, total_q;
  logic [POS_W-1:0]  lo_q;
  logic              pend_q, pend_neg_q;

  assign count_ext = NW'(elem_count_i);
  assign used_cnt  = (count_ext > MAX_NODE) ? MAX_NODE : count_ext;
  assign pos_ext   = NW'(position_i);
  assign low_bit   = node_q & (~node_q + NW'(1));
  assign node_up   = node_q + low_bit;
  assign node_dn   = node_q - low_bit;
  assign in_range  = (node_q != '0) && (node_q <= used_cnt);
  assign node_addr = AW'(node_q - NW'(1));

  always_comb begin
    node_d = node_q;
    if (cmd_i.start) begin
      node_d = (operation_i == OP_QUERY) ? NW'(range_high_i) + NW'(1) : pos_ext + NW'(1);
    end else if (cmd_i.clr_step) begin
      node_d = node_q + NW'(1);
    end else if (cmd_i.add_wr) begin
      node_d = node_up;
    end else if (cmd_i.q_step) begin
      node_d = node_dn;
    end else if (cmd_i.load_lo) begin
      node_d = NW'(lo_q);
    end
  end

  assign rd_en   = cmd_i.add_rd || (cmd_i.q_step && in_range);
  assign wr_en   = cmd_i.clr_step || cmd_i.add_wr;
  assign wr_addr = cmd_i.clr_step ? node_q[AW-1:0] : node_addr;
  assign wr_data = cmd_i.clr_step ? '0 : rd_data_q + delta_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_data_q <= mem[node_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q     <= '0;
      pend_q     <= 1'b0;
      pend_neg_q <= 1'b0;
    end else begin
      node_q     <= node_d;
      pend_q     <= cmd_i.q_step && in_range;
      pend_neg_q <= cmd_i.q_neg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      delta_q <= delta_i;
      lo_q    <= range_low_i;
      acc_q   <= '0;
    end else if (pend_q) begin
      acc_q <= pend_neg_q ? acc_q - rd_data_q : acc_q + rd_data_q;
    end
    if (cmd_i.out_load) total_q <= acc_q;
  end

  assign sts_o.add_skip    = (pos_ext >= used_cnt);
  assign sts_o.node_zero   = (node_q == '0);
  assign sts_o.up_in_range = (node_up <= used_cnt);
  assign sts_o.clr_last    = (node_q == MAX_NODE - NW'(1));

  assign range_total_o = total_q;

endmodule

FILE: rtl/fenwick_prefix_sum_table.sv
// Top level: a binary indexed tree of signed 32-bit sums with add and range-sum items.
// One item is in flight at a time: input transfers stay stalled until the block is idle again.
// An add reads and then writes each node of its upward walk, over up to 11 tree nodes.
// A range sum walks down from each of its two prefix ends in turn, then loads the result;
// the load waits while an earlier result is still stalled.
// Reset is asynchronous and active low; a clear pass then zeroes one entry per cycle over all
// MAX_ELEMS entries, during which input transfers are stalled.
module fenwick_prefix_sum_table import fps_pkg::*; #(
  parameter int MAX_ELEMS = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration port.
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,
  // Input item channel.
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     operation_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] delta_i,
  input  logic [POS_W-1:0]         range_low_i,
  input  logic [POS_W-1:0]         range_high_i,
  // Result channel.
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] range_total_o
);

  // The only register is element_count at byte address zero. Every aligned word address
  // therefore selects it, so the write decode does not look at paddr.
  logic [CNT_W-1:0] elem_count_q;
  logic             cfg_write;

  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = (paddr == '0) ? PDATA_W'(elem_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_count_q <= CNT_RESET;
    end else if (cfg_write) begin
      elem_count_q <= pwdata[CNT_W-1:0];
    end
  end

  // The controller sequences the walks; the datapath owns the tree memory, the node
  // pointer and the running total. They talk only through the command and status structs.
  cmd_t cmd;
  sts_t sts;

  fps_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  fps_datapath #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .elem_count_i  (elem_count_q),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .delta_i       (delta_i),
    .range_low_i   (range_low_i),
    .range_high_i  (range_high_i),
    .range_total_o (range_total_o)
  );

endmodule

FILE: rtl/fps_checker.sv
// Port-level checker for the prefix-sum table, bound to the top level.
module fps_checker import fps_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              operation_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [DATA_W-1:0] range_total_o
);

  // A result held back by the receiver stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(range_total_o)))
    else $error("result changed or dropped while stalled");

  // The clear pass keeps input transfers off right after reset.
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("input accepted during the clear pass");

  // A range sum always keeps the block busy in the next cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (operation_i == OP_QUERY)) |=> in_stall_o)
    else $error("range sum finished without walking the tree");

  // A new result is only produced at the end of a walk.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while the block was idle");

endmodule

bind fenwick_prefix_sum_table fps_checker u_fps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .operation_i   (operation_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .range_total_o (range_total_o)
);

FILE: test/tb.sv
// Self-checking testbench for the prefix-sum table: random and directed adds and range sums.
module tb;
  import fps_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PER_PHASE = 140;
  localparam logic [PADDR_W-1:0] ADDR_ELEMENT_COUNT = '0;

  typedef struct packed {
    logic                     op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] delta;
    logic [POS_W-1:0]         lo;
    logic [POS_W-1:0]         hi;
  } table_op_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_W-1:0]       paddr = '0;
  logic [PDATA_W-1:0]       pwdata = '0;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     operation_i = OP_ADD;
  logic [POS_W-1:0]         position_i = '0;
  logic signed [DATA_W-1:0] delta_i = '0;
  logic [POS_W-1:0]         range_low_i = '0;
  logic [POS_W-1:0]         range_high_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] range_total_o;

  fenwick_prefix_sum_table #(.MAX_ELEMS(TABLE_DEPTH)) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .position_i   (position_i),
    .delta_i      (delta_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .range_total_o(range_total_o)
  );

  // Shadow copy of the tree and of the element count register.
  logic [DATA_W-1:0] tree_nodes [TABLE_DEPTH];
  logic [CNT_W-1:0]  elem_count = CNT_RESET;

  table_op_t                queued_ops[$];
  logic signed [DATA_W-1:0] expected_totals[$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit          sender_idle_en = 1'b1;
  bit          receiver_stall_en = 1'b1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned used_count();
    return (elem_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(elem_count);
  endfunction

  // Downward walk: sum of the first k elements, nodes above the count read as zero.
  function automatic logic [DATA_W-1:0] prefix_total_of(int unsigned k);
    logic [DATA_W-1:0] acc;
    logic [31:0]       node;
    int unsigned       lim;
    acc = '0;
    node = k;
    lim = used_count();
    while (node != 0) begin
      if (node <= lim) acc += tree_nodes[IDX_W'(node - 32'd1)];
      node -= node & (~node + 32'd1);
    end
    return acc;
  endfunction

  function automatic void tree_add_delta(int unsigned pos, logic [DATA_W-1:0] amount);
    logic [31:0] node;
    int unsigned lim;
    lim = used_count();
    if (pos >= lim) return;
    for (node = pos + 1; node <= lim; node += node & (~node + 32'd1))
      tree_nodes[IDX_W'(node - 32'd1)] += amount;
  endfunction

  // Mostly no pause, sometimes a short one, rarely a long one.
  function automatic int unsigned pause_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_add(int unsigned pos, logic signed [DATA_W-1:0] amount);
    table_op_t t;
    t.op = OP_ADD;
    t.pos = pos[POS_W-1:0];
    t.delta = amount;
    t.lo = POS_W'($urandom());
    t.hi = POS_W'($urandom());
    queued_ops.push_back(t);
  endfunction

  function automatic void push_sum(int unsigned lo, int unsigned hi);
    table_op_t t;
    t.op = OP_QUERY;
    t.pos = POS_W'($urandom());
    t.delta = $urandom();
    t.lo = lo[POS_W-1:0];
    t.hi = hi[POS_W-1:0];
    queued_ops.push_back(t);
  endfunction

  function automatic int unsigned pick_position(int unsigned lim);
    if (lim > 0 && $urandom_range(0, 4) != 0) return $urandom_range(0, lim - 1);
    return $urandom_range(0, TABLE_DEPTH - 1);
  endfunction

  function automatic void push_random_op(int unsigned lim);
    int unsigned r;
    logic signed [DATA_W-1:0] amount;
    if ($urandom_range(0, 99) < 55) begin
      r = $urandom_range(0, 9);
      if (r < 4) amount = $signed($urandom_range(0, 200)) - 100;
      else if (r == 4) amount = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      else amount = $urandom();
      push_add(pick_position(lim), amount);
    end else begin
      push_sum(pick_position(lim), pick_position(lim));
    end
  endfunction

  // Block until every queued item has been taken and every expected total has arrived.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (queued_ops.size() != 0 || in_valid_i || expected_totals.size() != 0);
  endtask

  // An add gives no result, so the last one may still be walking the tree after the
  // final total arrives; let it finish before touching the register.
  task automatic write_element_count(input logic [CNT_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_ELEMENT_COUNT;
    pwdata <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    elem_count = value;
  endtask

  // Input driver: predicts each transfer as it is accepted, then loads the next item.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (operation_i == OP_QUERY)
        expected_totals.push_back(prefix_total_of(int'(range_high_i) + 1) -
                                  prefix_total_of(int'(range_low_i)));
      else
        tree_add_delta(int'(position_i), delta_i);
    end
    if (!in_valid_i || !in_stall_o) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (rst_ni && queued_ops.size() > 0) begin
        table_op_t t;
        t = queued_ops.pop_front();
        operation_i <= t.op;
        position_i <= t.pos;
        delta_i <= t.delta;
        range_low_i <= t.lo;
        range_high_i <= t.hi;
        in_valid_i <= 1'b1;
        send_gap = sender_idle_en ? pause_length() : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_totals.size() == 0) begin
        $error("range_total: unexpected result %0d", range_total_o);
        fail_count++;
      end else begin
        logic signed [DATA_W-1:0] want;
        want = expected_totals.pop_front();
        if (range_total_o !== want) begin
          $error("range_total mismatch: expected %0d, actual %0d", want, range_total_o);
          fail_count++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (receiver_stall_en) stall_left = pause_length();
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [CNT_W-1:0] phase_counts [10];
    for (int k = 0; k < TABLE_DEPTH; k++) tree_nodes[IDX_W'(k)] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, wrapping, reversed ranges, full-table sums.
    push_sum(0, 1023);
    push_add(0, 32'sh7fffffff);
    push_add(1023, 32'sh80000000);
    push_add(512, -1);
    push_add(0, 1);
    push_sum(0, 0);
    push_sum(1023, 1023);
    push_sum(0, 1023);
    push_sum(1023, 0);
    push_sum(512, 512);
    push_add(1, 5);
    push_add(2, -7);
    push_sum(1, 2);
    push_sum(2, 1);

    // Count lowered after adds: upper nodes keep their values but read as zero.
    write_element_count(11'd3);
    push_add(5, 100);
    push_add(2, 9);
    push_sum(0, 1023);
    push_sum(0, 2);
    push_sum(3, 3);

    // Count above the table size clamps to the full table.
    write_element_count(11'd2047);
    push_sum(0, 1023);
    push_sum(3, 1023);

    phase_counts = '{11'd1024, 11'd0, 11'd1, 11'd2, 11'd2047, 11'd1023,
                     11'd0, 11'd64, 11'd0, 11'd1024};
    phase_counts[6] = CNT_W'($urandom_range(3, 1023));
    phase_counts[8] = CNT_W'($urandom_range(3, 1023));

    for (int ph = 0; ph < 10; ph++) begin
      write_element_count(phase_counts[ph]);
      sender_idle_en = (ph % 3 != 2);
      receiver_stall_en = (ph % 3 != 2) && (ph != 4);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) push_random_op(used_count());
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_totals.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
